FILE: rtl/core/svc_pkg.sv
// Shared types for the signed varint codec.
// Holds the queue entry format and the queue fill status struct; no dependencies.
`default_nettype none

package svc_pkg;

    // Kind of work handed from the front end to the back end
    typedef enum logic {
        KIND_DEC = 1'b0,
        KIND_ENC = 1'b1
    } svc_kind_t;

    // Bit masks of the encoded format
    localparam logic [7:0] SIGN_BIT  = 8'h80;
    localparam logic [7:0] MORE_BIT  = 8'h40;
    localparam logic [7:0] LOW6_MASK = 8'h3F;
    localparam logic [7:0] LOW7_MASK = 8'h7F;

    // One queued job: a finished decode value or a value waiting to be encoded.
    // flag is the overflow mark for a decode job and the sign for an encode job.
    // data is the signed result for a decode job and the magnitude for an encode job.
    typedef struct packed {
        svc_kind_t   kind;
        logic        flag;
        logic [2:0]  nbytes;
        logic [31:0] data;
    } svc_op_t;

    // Queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } svc_qstat_t;

endpackage

`default_nettype wire

FILE: rtl/core/svc_queue.sv
// Short FIFO of jobs between the front end and the back end.
// Depends on svc_pkg for the entry and status types.
`default_nettype none

module svc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire svc_pkg::svc_op_t push_op,
    input  wire logic            pop,
    output svc_pkg::svc_op_t     head_op,
    output svc_pkg::svc_qstat_t  stat
);
    import svc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    svc_op_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push & ~stat.full;
    assign do_pop     = pop & ~stat.empty;
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push & ~do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop & ~do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/svc_front.sv
// Front end of the codec: accepts input transfers, runs the byte decoder state
// and sizes values for encoding. Depends on svc_pkg.
`default_nettype none

module svc_front #(
    parameter int MAX_BYTES = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic               cfg_dir,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         in_byte,
    input  wire logic signed [31:0] in_value,
    input  wire svc_pkg::svc_qstat_t qstat,
    output logic                    push,
    output svc_pkg::svc_op_t        push_op
);
    import svc_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);

    logic          dir_reg;
    logic [30:0]   acc_reg, acc_next;
    logic [CW-1:0] count_reg, count_next;
    logic          sign_reg, sign_next;
    logic          prog_reg, prog_next;

    logic          accept;
    logic [6:0]    payload;
    logic          more;
    logic          ovf;
    logic          emit;
    logic [CW-1:0] count_inc;
    logic [30:0]   acc_new;
    logic          sign_new;
    logic [31:0]   dec_value;
    logic [31:0]   raw;
    logic [31:0]   mag;
    logic [2:0]    nbytes;

    assign in_ready = ~qstat.full;
    assign accept   = in_valid & in_ready;
    assign payload  = in_byte[6:0];
    assign more     = (in_byte & SIGN_BIT) != 8'h00;
    assign count_inc = count_reg + 1'b1;

    // Decode step on the accepted byte
    always_comb
    begin
        acc_new  = acc_reg;
        sign_new = sign_reg;
        ovf      = 1'b0;
        emit     = 1'b0;
        if (!prog_reg)
        begin
            sign_new = in_byte[7];
            acc_new  = {25'd0, in_byte[5:0]};
            emit     = ~in_byte[6];
        end
        else
        begin
            case (count_reg)
                CW'(1):  acc_new = acc_reg | {18'd0, payload, 6'd0};
                CW'(2):  acc_new = acc_reg | {11'd0, payload, 13'd0};
                CW'(3):  acc_new = acc_reg | {4'd0, payload, 20'd0};
                CW'(4):
                begin
                    acc_new = acc_reg | {payload[3:0], 27'd0};
                    ovf     = |payload[6:4];
                end
                default: ovf = |payload;
            endcase
            if (more && (count_inc >= CW'(MAX_BYTES)))
            begin
                ovf = 1'b1;
            end
            emit = ovf | ~more;
        end
        dec_value = sign_new ? (32'd0 - {1'b0, acc_new}) : {1'b0, acc_new};
    end

    // Size the value to encode
    always_comb
    begin
        raw = in_value;
        mag = raw[31] ? (32'd0 - raw) : raw;
        if (mag < 32'h0000_0040)
        begin
            nbytes = 3'd1;
        end
        else if (mag < 32'h0000_2000)
        begin
            nbytes = 3'd2;
        end
        else if (mag < 32'h0010_0000)
        begin
            nbytes = 3'd3;
        end
        else if (mag < 32'h0800_0000)
        begin
            nbytes = 3'd4;
        end
        else
        begin
            nbytes = 3'd5;
        end
    end

    always_comb
    begin
        push    = 1'b0;
        push_op = '0;
        acc_next   = acc_reg;
        count_next = count_reg;
        sign_next  = sign_reg;
        prog_next  = prog_reg;
        if (cfg_write)
        begin
            acc_next   = '0;
            count_next = '0;
            sign_next  = 1'b0;
            prog_next  = 1'b0;
        end
        else if (accept && dir_reg)
        begin
            push           = 1'b1;
            push_op.kind   = KIND_ENC;
            push_op.flag   = raw[31];
            push_op.nbytes = nbytes;
            push_op.data   = mag;
        end
        else if (accept)
        begin
            if (emit)
            begin
                push           = 1'b1;
                push_op.kind   = KIND_DEC;
                push_op.flag   = ovf;
                push_op.nbytes = 3'd1;
                push_op.data   = dec_value;
                acc_next   = '0;
                count_next = '0;
                sign_next  = 1'b0;
                prog_next  = 1'b0;
            end
            else
            begin
                acc_next   = acc_new;
                sign_next  = sign_new;
                prog_next  = 1'b1;
                count_next = prog_reg ? count_inc : CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 1'b0;
            acc_reg   <= '0;
            count_reg <= '0;
            sign_reg  <= 1'b0;
            prog_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                dir_reg <= cfg_dir;
            end
            acc_reg   <= acc_next;
            count_reg <= count_next;
            sign_reg  <= sign_next;
            prog_reg  <= prog_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/svc_back.sv
// Back end of the codec: drains jobs from the queue and drives the output
// register, one transfer per cycle while work is waiting and out_ready allows it. Depends on svc_pkg.
`default_nettype none

module svc_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire svc_pkg::svc_op_t   head_op,
    input  wire svc_pkg::svc_qstat_t qstat,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [39:0]             out_data,
    output logic [2:0]              out_user,
    output logic                    out_last
);
    import svc_pkg::*;

    logic          busy_reg, busy_next;
    logic [25:0]   mag_reg, mag_next;
    logic [2:0]    left_reg, left_next;
    logic          valid_reg, valid_next;
    logic [39:0]   data_reg, data_next;
    logic [2:0]    user_reg, user_next;
    logic          last_reg, last_next;

    logic          load_ok;
    logic          produce;

    assign load_ok = ~valid_reg | out_ready;
    assign produce = (busy_reg | ~qstat.empty) & load_ok;
    assign pop     = produce & ~busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        mag_next   = mag_reg;
        left_next  = left_reg;
        valid_next = valid_reg & ~out_ready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (produce)
        begin
            valid_next = 1'b1;
            if (busy_reg)
            begin
                // Continuation byte of an encode burst
                data_next = {32'd0, (left_reg > 3'd1), mag_reg[6:0]};
                user_next = 3'b010;
                last_next = (left_reg == 3'd1);
                mag_next  = mag_reg >> 7;
                left_next = left_reg - 3'd1;
                busy_next = (left_reg != 3'd1);
            end
            else if (head_op.kind == KIND_DEC)
            begin
                data_next = {head_op.data, 8'd0};
                user_next = {head_op.flag, 2'b01};
                last_next = 1'b1;
            end
            else
            begin
                // First byte: sign, more mark, low six magnitude bits
                data_next = {32'd0, head_op.flag, (head_op.nbytes > 3'd1),
                             head_op.data[5:0]};
                user_next = 3'b010;
                last_next = (head_op.nbytes == 3'd1);
                mag_next  = head_op.data[31:6];
                left_next = head_op.nbytes - 3'd1;
                busy_next = (head_op.nbytes > 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_user  = user_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/signed_varint_codec.sv
// Top level of the signed varint codec: front end, job queue and back end.
// Depends on svc_pkg, svc_front, svc_queue and svc_back.
`default_nettype none

// Sign-magnitude varint codec. The first byte carries the sign in bit 7, a
// "more" mark in bit 6 and magnitude bits 5..0; each following byte carries
// seven magnitude bits and its own "more" mark in bit 7. Write cfg_data = 0 to
// decode (one byte per input transfer, one value out when a run ends) and 1 to
// encode (one value per input transfer, one to five bytes out, the final byte
// marked by m_tlast). A direction write drops any open decode run; write it only
// while nothing is in flight. Decoding takes one byte per cycle while the queue
// is not full: the front end updates the run state in the cycle the byte is
// taken. When encoding, the back end turns each value into its run of N = 1..5
// bytes and sends one byte per cycle into the output register while m_tready
// does not hold it. A queue of QUEUE_DEPTH jobs sits between the two, so input
// transfers go on while a burst drains or while m_tready is low. An input
// transfer reaches the output through the queue storage and the output register.
// Runs longer than MAX_BYTES bytes, or with magnitude bits above bit 30, come
// out at once with the overflow flag set; the next byte starts a new run. Negative zero decodes as 0.
module signed_varint_codec #(
    parameter int MAX_BYTES   = 5,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,    // direction
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,     // [7:0] in_byte, [39:8] in_value
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,     // [7:0] out_byte, [39:8] out_value
    output logic [2:0]       m_tuser,     // [0] value_valid, [1] byte_valid, [2] overflow
    output logic             m_tlast
);
    import svc_pkg::*;

    svc_op_t    push_op;
    svc_op_t    head_op;
    svc_qstat_t qstat;
    logic       push;
    logic       pop;
    logic       cfg_write;

    // Configuration is always taken at once
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    svc_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_dir   (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata[7:0]),
        .in_value  (s_tdata[39:8]),
        .qstat     (qstat),
        .push      (push),
        .push_op   (push_op)
    );

    svc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .stat    (qstat)
    );

    svc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_op   (head_op),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire
